// File: rtl/bdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types, constants and helpers for the button debounce and
// long-press detector.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int REG_WIDTH   = 16;
	localparam int NUM_BTN     = 3;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [REG_WIDTH-1:0]   cfg_word_t;
	typedef logic [NUM_BTN-1:0]     btn_t;

	localparam logic [31:0] CNT_MAX_W = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	localparam cfg_word_t DEBOUNCE_RESET = REG_WIDTH'(100);
	localparam cfg_word_t HOLD_RESET     = REG_WIDTH'(1000);

	// register indexes on the config port
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_HOLD     = 1'b1;

	// input kind codes
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_EDGE = 1'b1;

	// button bit positions
	localparam int BTN_LL = 0;
	localparam int BTN_UR = 2;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_START = 4'b0010,
		PH_HOLD  = 4'b0100,
		PH_STOP  = 4'b1000
	} phase_t;

	typedef struct packed {
		btn_t buttons;
		logic held_long;
		logic go_main;
		logic advance_next;
		logic abort_view;
	} report_t;

	// zero loads as one, values above the counter range saturate
	function automatic count_t load_value(input cfg_word_t r);
		logic [31:0] v;
		v = (r == '0) ? 32'd1 : 32'(r);
		if (v > CNT_MAX_W) begin
			v = CNT_MAX_W;
		end
		return v[COUNT_WIDTH-1:0];
	endfunction

	function automatic report_t make_report(input btn_t b, input logic is_long);
		report_t r;
		r.buttons      = b;
		r.held_long    = is_long;
		r.go_main      = b[BTN_LL] & is_long;
		r.advance_next = b[BTN_LL];
		r.abort_view   = b[BTN_LL] | (b[BTN_UR] & ~is_long);
		return r;
	endfunction

endpackage

// File: rtl/bdlp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_core
// Phase machine, shared one-shot countdown and latched button mask; turns
// one tick or edge beat into at most one press report.
// ----------------------------------------------------------------------------
module bdlp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic               kind,
	input  bdlp_pkg::btn_t     edges,
	input  bdlp_pkg::btn_t     levels,
	input  bdlp_pkg::cfg_word_t debounce_ticks,
	input  bdlp_pkg::cfg_word_t hold_ticks,
	output logic               rpt_fire,
	output bdlp_pkg::report_t  rpt
);
	import bdlp_pkg::*;

	phase_t phase_q, phase_d;
	count_t cnt_q, cnt_d, cnt_dec;
	btn_t   latched_q, latched_d;
	logic   fire;
	logic   is_long;

	assign cnt_dec = cnt_q - count_t'(1);

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		latched_d = latched_q;
		fire      = 1'b0;
		is_long   = 1'b0;
		if (kind == KIND_EDGE) begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_d   = PH_START;
					latched_d = edges;
					cnt_d     = load_value(debounce_ticks);
				end
				PH_HOLD: begin
					// release while hold count still runs is a short press
					phase_d = PH_STOP;
					cnt_d   = load_value(debounce_ticks);
					fire    = (cnt_q != '0);
				end
				default: begin
				end
			endcase
		end else if (cnt_q != '0) begin
			cnt_d = cnt_dec;
			if (cnt_dec == '0) begin
				unique case (phase_q)
					PH_START: begin
						if (levels != '0) begin
							phase_d = PH_HOLD;
							cnt_d   = load_value(hold_ticks);
						end else begin
							phase_d = PH_IDLE;
							fire    = 1'b1;
						end
					end
					PH_HOLD: begin
						fire    = 1'b1;
						is_long = 1'b1;
					end
					PH_STOP: begin
						phase_d = PH_IDLE;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			latched_q <= '0;
		end else if (go) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			latched_q <= latched_d;
		end
	end

	assign rpt_fire = go & fire;
	assign rpt      = make_report(latched_q, is_long);

	// timer is always stopped while idle
	a_idle_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> cnt_q == '0)
		else $error("countdown running while idle");

	a_report_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_fire |-> (phase_q == PH_START || phase_q == PH_HOLD))
		else $error("report outside start or hold");

	a_edge_starts: assert property (@(posedge clk) disable iff (!arst_n)
		go && kind == KIND_EDGE && phase_q == PH_IDLE
		|=> phase_q == PH_START && cnt_q != '0)
		else $error("edge in idle did not start debounce");

	a_long_once: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_fire && rpt.held_long |=> phase_q == PH_HOLD && cnt_q == '0)
		else $error("long press did not stop the countdown");

endmodule

// File: rtl/button_debounce_long_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounces three pushbuttons from tick and edge beats and reports short
// and long presses with derived navigation flags.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in       | sink      | in_valid/in_stall  | kind, edge_buttons, level_buttons
//  out      | source    | out_valid/out_stall| buttons, held_long, go_main,
//           |           |                    | advance_next, abort_view
//  cfg      | sink      | cfg_we             | cfg_index, cfg_data
//
// one beat per cycle while in_stall is low; a report is valid on out once
// it is registered, after its beat has passed the input register.
// the input register feeds the phase machine, the result register holds
// the report; in_stall rises only while a report sits stalled in it.
// arst_n clears phase, countdown, latched mask and loads default counts.
// ----------------------------------------------------------------------------
module button_debounce_long_press (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [2:0]          edge_buttons,
	input  logic [2:0]          level_buttons,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          buttons,
	output logic                held_long,
	output logic                go_main,
	output logic                advance_next,
	output logic                abort_view,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  bdlp_pkg::cfg_word_t cfg_data
);
	import bdlp_pkg::*;

	cfg_word_t debounce_q, hold_q;

	logic    valid_s1, kind_s1;
	btn_t    edges_s1, levels_s1;
	logic    valid_s2;
	report_t rpt_s2;

	logic    out_blocked, go, rpt_fire;
	report_t rpt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			hold_q     <= HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_HOLD:     hold_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_blocked = valid_s2 & out_stall;
	assign go          = valid_s1 & ~out_blocked;
	assign in_stall    = valid_s1 & out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1   <= kind;
			edges_s1  <= edge_buttons;
			levels_s1 <= level_buttons;
		end
	end

	bdlp_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (go),
		.kind           (kind_s1),
		.edges          (edges_s1),
		.levels         (levels_s1),
		.debounce_ticks (debounce_q),
		.hold_ticks     (hold_q),
		.rpt_fire       (rpt_fire),
		.rpt            (rpt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rpt_fire) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_fire) begin
			rpt_s2 <= rpt;
		end
	end

	assign out_valid    = valid_s2;
	assign buttons      = rpt_s2.buttons;
	assign held_long    = rpt_s2.held_long;
	assign go_main      = rpt_s2.go_main;
	assign advance_next = rpt_s2.advance_next;
	assign abort_view   = rpt_s2.abort_view;

endmodule
